[design/spd_pkg.sv]
// Shared types and constants for the serial pattern demultiplexer.
package spd_pkg;

  localparam int unsigned WINDOW_BITS_DEF = 16;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 1;

  localparam logic [CFG_W-1:0] ZERO_PATTERN_RST   = 16'hF628;
  localparam logic [CFG_W-1:0] REPEAT_PATTERN_RST = 16'h28F6;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_PATTERN   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_PATTERN = 1'b1;

  typedef enum logic [1:0] {
    MD_FILL   = 2'd0,
    MD_ROUTE  = 2'd1,
    MD_CLEAR  = 2'd2,
    MD_REPLAY = 2'd3
  } spd_mode_e;

  typedef struct packed {
    logic      even_line;
    logic      odd_line;
    spd_mode_e mode;
  } spd_result_t;

endpackage

[design/spd_core.sv]
// Window, mode and line-level state with the per-bit update logic.
module spd_core #(
  parameter int unsigned WINDOW_BITS = spd_pkg::WINDOW_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     bit_i,
  input  logic [spd_pkg::CFG_W-1:0] zero_pattern_i,
  input  logic [spd_pkg::CFG_W-1:0] repeat_pattern_i,
  output spd_pkg::spd_result_t     result_o
);

  localparam int unsigned CntW = $clog2(WINDOW_BITS + 1);
  localparam int unsigned PosW = $clog2(WINDOW_BITS);

  logic [WINDOW_BITS-1:0] zero_cmp;
  logic [WINDOW_BITS-1:0] repeat_cmp;

  if (WINDOW_BITS <= spd_pkg::CFG_W) begin : g_cmp_trunc
    assign zero_cmp   = zero_pattern_i[WINDOW_BITS-1:0];
    assign repeat_cmp = repeat_pattern_i[WINDOW_BITS-1:0];
  end else begin : g_cmp_ext
    assign zero_cmp   = {{(WINDOW_BITS - spd_pkg::CFG_W){1'b0}}, zero_pattern_i};
    assign repeat_cmp = {{(WINDOW_BITS - spd_pkg::CFG_W){1'b0}}, repeat_pattern_i};
  end

  logic [WINDOW_BITS-1:0] window_q, window_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   ready_q, ready_d;
  spd_pkg::spd_mode_e     mode_q, mode_d;
  logic [WINDOW_BITS-1:0] replay_word_q, replay_word_d;
  logic [PosW-1:0]        replay_pos_q, replay_pos_d;
  logic [WINDOW_BITS-1:0] saved_window_q, saved_window_d;
  logic                   saved_valid_q, saved_valid_d;
  logic                   parity_q, parity_d;
  logic                   even_q, even_d;
  logic                   odd_q, odd_d;
  logic                   route_bit;

  always_comb begin
    window_d       = {window_q[WINDOW_BITS-2:0], bit_i};
    count_d        = count_q;
    ready_d        = ready_q;
    mode_d         = mode_q;
    replay_word_d  = replay_word_q;
    replay_pos_d   = replay_pos_q;
    saved_window_d = saved_window_q;
    saved_valid_d  = saved_valid_q;
    parity_d       = ~parity_q;
    even_d         = even_q;
    odd_d          = odd_q;
    route_bit      = bit_i;

    if (!ready_q) begin
      count_d = count_q + 1'b1;
      if (count_d == CntW'(WINDOW_BITS)) begin
        ready_d = 1'b1;
        mode_d  = spd_pkg::MD_ROUTE;
      end
    end

    if (ready_d) begin
      if (window_d == zero_cmp) begin
        mode_d = spd_pkg::MD_CLEAR;
      end else if (window_d == repeat_cmp) begin
        if (saved_valid_q && (mode_d != spd_pkg::MD_REPLAY)) begin
          mode_d        = spd_pkg::MD_REPLAY;
          replay_word_d = saved_window_q;
          replay_pos_d  = '0;
        end
      end else begin
        mode_d         = spd_pkg::MD_ROUTE;
        saved_window_d = window_d;
        saved_valid_d  = 1'b1;
      end

      case (mode_d)
        spd_pkg::MD_ROUTE: begin
          route_bit = bit_i;
          if (parity_q) odd_d = route_bit;
          else          even_d = route_bit;
        end
        spd_pkg::MD_CLEAR: begin
          even_d = 1'b0;
          odd_d  = 1'b0;
        end
        spd_pkg::MD_REPLAY: begin
          route_bit = replay_word_d[PosW'(WINDOW_BITS - 1) - replay_pos_d];
          if (parity_q) odd_d = route_bit;
          else          even_d = route_bit;
          if (replay_pos_d == PosW'(WINDOW_BITS - 1)) replay_pos_d = '0;
          else                                        replay_pos_d = replay_pos_d + 1'b1;
        end
        default: begin
          even_d = even_q;
          odd_d  = odd_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q       <= '0;
      count_q        <= '0;
      ready_q        <= 1'b0;
      mode_q         <= spd_pkg::MD_FILL;
      replay_word_q  <= '0;
      replay_pos_q   <= '0;
      saved_window_q <= '0;
      saved_valid_q  <= 1'b0;
      parity_q       <= 1'b0;
      even_q         <= 1'b0;
      odd_q          <= 1'b0;
    end else if (step_i) begin
      window_q       <= window_d;
      count_q        <= count_d;
      ready_q        <= ready_d;
      mode_q         <= mode_d;
      replay_word_q  <= replay_word_d;
      replay_pos_q   <= replay_pos_d;
      saved_window_q <= saved_window_d;
      saved_valid_q  <= saved_valid_d;
      parity_q       <= parity_d;
      even_q         <= even_d;
      odd_q          <= odd_d;
    end
  end

  assign result_o.even_line = even_d;
  assign result_o.odd_line  = odd_d;
  assign result_o.mode      = mode_d;

endmodule

[design/serial_pattern_demux_unit.sv]
// Top level: pattern registers, input register, result register and core.
//
//  Channel   Direction  Handshake                Payload
//  cfg       in         cfg_we_i                 cfg_idx_i, cfg_wdata_i
//  in        in         in_valid_i / in_ready_o  serial_bit_i
//  out       out        out_valid_o / out_ready_i even_line_o, odd_line_o, mode_code_o
//
// A transaction's result reaches the output in steps after acceptance: the bit
// waits in the input register, then the state update fills the result register.
// One transaction is accepted per cycle while the output is taken.
// A held result stalls the input register, then in_ready_o drops.
// Reset clears the window, mode, lines and both handshakes; patterns reload.
module serial_pattern_demux_unit #(
  parameter int unsigned WINDOW_BITS = spd_pkg::WINDOW_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          serial_bit_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          even_line_o,
  output logic                          odd_line_o,
  output logic [1:0]                    mode_code_o
);

  logic [spd_pkg::CFG_W-1:0] zero_pattern_q;
  logic [spd_pkg::CFG_W-1:0] repeat_pattern_q;
  logic                      in_valid_q;
  logic                      in_bit_q;
  logic                      out_valid_q;
  spd_pkg::spd_result_t      out_q;
  spd_pkg::spd_result_t      result;
  logic                      advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_pattern_q   <= spd_pkg::ZERO_PATTERN_RST;
      repeat_pattern_q <= spd_pkg::REPEAT_PATTERN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spd_pkg::REG_ZERO_PATTERN:   zero_pattern_q   <= cfg_wdata_i;
        spd_pkg::REG_REPEAT_PATTERN: repeat_pattern_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_bit_q <= serial_bit_i;
    end
  end

  spd_core #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (advance),
    .bit_i           (in_bit_q),
    .zero_pattern_i  (zero_pattern_q),
    .repeat_pattern_i(repeat_pattern_q),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign even_line_o = out_q.even_line;
  assign odd_line_o  = out_q.odd_line;
  assign mode_code_o = out_q.mode;

endmodule

[design/spd_checker.sv]
// Port-level checks for the serial pattern demultiplexer, bound to the top.
module spd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       even_line_o,
  input logic       odd_line_o,
  input logic [1:0] mode_code_o
);

  logic left_startup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_startup_q <= 1'b0;
    end else if (out_valid_o && out_ready_i &&
                 (mode_code_o != spd_pkg::MD_FILL)) begin
      left_startup_q <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable(even_line_o) && $stable(odd_line_o) && $stable(mode_code_o))
    else $error("result changed while stalled");

  a_zero_lines_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_code_o == spd_pkg::MD_CLEAR) |-> !even_line_o && !odd_line_o)
    else $error("zero mode with a line high");

  a_startup_lines_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_code_o == spd_pkg::MD_FILL) |-> !even_line_o && !odd_line_o)
    else $error("startup mode with a line high");

  a_no_startup_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && left_startup_q |-> (mode_code_o != spd_pkg::MD_FILL))
    else $error("startup mode after window was ready");

endmodule

bind serial_pattern_demux_unit spd_checker u_spd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .even_line_o(even_line_o),
  .odd_line_o (odd_line_o),
  .mode_code_o(mode_code_o)
);

[verif/serial_pattern_demux_unit_tb.sv]
// Testbench for serial_pattern_demux_unit: random serial streams checked against a line predictor.
module serial_pattern_demux_unit_tb;

  localparam int unsigned WB         = spd_pkg::WINDOW_BITS_DEF;
  localparam int unsigned CW         = spd_pkg::CFG_W;
  localparam int unsigned IW         = spd_pkg::CFG_IDX_W;
  localparam int unsigned QUIET_MAX  = 3000;
  localparam int unsigned HOLD_LEN   = 80;
  localparam int unsigned REPORT_MAX = 10;

  class demux_scoreboard;
    logic [CW-1:0]        zero_pat;
    logic [CW-1:0]        rep_pat;
    logic [WB-1:0]        win;
    int unsigned          boot_cnt;
    logic                 win_full;
    spd_pkg::spd_mode_e   mode;
    logic [WB-1:0]        replay_word;
    int unsigned          replay_pos;
    logic [WB-1:0]        saved_win;
    logic                 saved_ok;
    logic                 phase;
    logic                 even_lvl;
    logic                 odd_lvl;
    spd_pkg::spd_result_t expected_lines[$];
    int unsigned          mismatches;

    function new();
      zero_pat    = spd_pkg::ZERO_PATTERN_RST;
      rep_pat     = spd_pkg::REPEAT_PATTERN_RST;
      win         = '0;
      boot_cnt    = 0;
      win_full    = 1'b0;
      mode        = spd_pkg::MD_FILL;
      replay_word = '0;
      replay_pos  = 0;
      saved_win   = '0;
      saved_ok    = 1'b0;
      phase       = 1'b0;
      even_lvl    = 1'b0;
      odd_lvl     = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [IW-1:0] idx, logic [CW-1:0] val);
      if (idx == spd_pkg::REG_ZERO_PATTERN) begin
        zero_pat = val;
      end else if (idx == spd_pkg::REG_REPEAT_PATTERN) begin
        rep_pat = val;
      end
    endfunction

    function void route(logic v);
      if (!phase) begin
        even_lvl = v;
      end else begin
        odd_lvl = v;
      end
    endfunction

    function void note_bit(logic b);
      spd_pkg::spd_result_t r;
      win = {win[WB-2:0], b};
      if (!win_full) begin
        boot_cnt++;
        if (boot_cnt >= WB) begin
          win_full = 1'b1;
          mode     = spd_pkg::MD_ROUTE;
        end
      end
      if (win_full) begin
        if (win == zero_pat[WB-1:0]) begin
          mode = spd_pkg::MD_CLEAR;
        end else if (win == rep_pat[WB-1:0]) begin
          if (saved_ok && mode != spd_pkg::MD_REPLAY) begin
            mode        = spd_pkg::MD_REPLAY;
            replay_word = saved_win;
            replay_pos  = 0;
          end
        end else begin
          mode      = spd_pkg::MD_ROUTE;
          saved_win = win;
          saved_ok  = 1'b1;
        end
        case (mode)
          spd_pkg::MD_ROUTE: begin
            route(b);
          end
          spd_pkg::MD_CLEAR: begin
            even_lvl = 1'b0;
            odd_lvl  = 1'b0;
          end
          spd_pkg::MD_REPLAY: begin
            route(replay_word[WB-1-replay_pos]);
            replay_pos = (replay_pos + 1) % WB;
          end
          default: begin
          end
        endcase
      end
      phase = ~phase;
      r.even_line = even_lvl;
      r.odd_line  = odd_lvl;
      r.mode      = mode;
      expected_lines.push_back(r);
    endfunction

    function void check_lines(logic even, logic odd, logic [1:0] mode_got);
      spd_pkg::spd_result_t r;
      if (expected_lines.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("unexpected transaction: even=%0b odd=%0b mode=%0d", even, odd, mode_got);
        end
        return;
      end
      r = expected_lines.pop_front();
      if (r.even_line !== even || r.odd_line !== odd || r.mode !== mode_got) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("mismatch: exp even=%0b odd=%0b mode=%0d, got even=%0b odd=%0b mode=%0d",
                   r.even_line, r.odd_line, r.mode, even, odd, mode_got);
        end
      end
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          cfg_we_i;
  logic [IW-1:0] cfg_idx_i;
  logic [CW-1:0] cfg_wdata_i;
  logic          in_valid_i;
  logic          in_ready_o;
  logic          serial_bit_i;
  logic          out_valid_o;
  logic          out_ready_i;
  logic          even_line_o;
  logic          odd_line_o;
  logic [1:0]    mode_code_o;

  demux_scoreboard sb;
  logic            gaps_on;
  logic            hold_req;
  int unsigned     bits_sent;
  int unsigned     quiet_cnt;
  logic [CW-1:0]   zp;
  logic [CW-1:0]   rp;

  serial_pattern_demux_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .serial_bit_i(serial_bit_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .even_line_o (even_line_o),
    .odd_line_o  (odd_line_o),
    .mode_code_o (mode_code_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sb.note_bit(serial_bit_i);
      end
      if (out_valid_o && out_ready_i) begin
        sb.check_lines(even_line_o, odd_line_o, mode_code_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cnt <= 0;
    end else begin
      quiet_cnt <= quiet_cnt + 1;
    end
    if (quiet_cnt >= QUIET_MAX) begin
      $display("[serial_pattern_demux_unit] ERROR");
      $finish;
    end
  end

  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_LEN - 1) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        out_ready_i <= !gaps_on || ($urandom_range(99) >= 24);
      end
    end
  end

  task automatic put_bit(input logic b);
    int unsigned gap;
    if (gaps_on && $urandom_range(99) < 24) begin
      gap = $urandom_range(3, 1);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    serial_bit_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    bits_sent++;
  endtask

  task automatic put_word(input logic [WB-1:0] w, input int unsigned len);
    for (int i = len - 1; i >= 0; i--) begin
      put_bit(w[i]);
    end
  endtask

  task automatic put_run(input logic b, input int unsigned len);
    repeat (len) put_bit(b);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic set_patterns(input logic [CW-1:0] z, input logic [CW-1:0] r);
    write_reg(spd_pkg::REG_ZERO_PATTERN, z);
    write_reg(spd_pkg::REG_REPEAT_PATTERN, r);
    zp = z;
    rp = r;
  endtask

  task automatic run_stream(input int unsigned n, input logic with_hold);
    int unsigned stop_at;
    int unsigned pick;
    stop_at = bits_sent + n;
    if (with_hold) begin
      hold_req = 1'b1;
    end
    while (bits_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        put_word(rp, WB);
        put_word(WB'($urandom), $urandom_range(WB - 1, 1));
      end else if (pick < 50) begin
        put_word(zp, WB);
        put_run(1'($urandom_range(1)), $urandom_range(4));
      end else if (pick < 62) begin
        put_run(1'($urandom_range(1)), $urandom_range(24, 1));
      end else if (pick < 75) begin
        put_word(rp, WB);
        put_word(WB'($urandom), $urandom_range(6, 1));
        put_word(zp, WB);
        put_word(rp, WB);
      end else begin
        put_word(WB'($urandom), $urandom_range(WB, 1));
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= spd_pkg::REG_ZERO_PATTERN;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    serial_bit_i <= 1'b0;
    gaps_on      = 1'b1;
    hold_req     = 1'b0;
    bits_sent    = 0;
    quiet_cnt    = 0;
    zp           = spd_pkg::ZERO_PATTERN_RST;
    rp           = spd_pkg::REPEAT_PATTERN_RST;
    sb           = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put_word(spd_pkg::REPEAT_PATTERN_RST, WB);
    put_run(1'b1, 3);
    put_run(1'b0, 3);
    put_word(spd_pkg::ZERO_PATTERN_RST, 3);
    run_stream(85, 1'b1);
    drain();

    set_patterns(16'h0000, 16'hFFFF);
    gaps_on = 1'b0;
    run_stream(95, 1'b0);
    drain();

    gaps_on = 1'b1;
    set_patterns(16'hFFFF, 16'h0000);
    run_stream(95, 1'b0);
    drain();

    zp = CW'($urandom);
    set_patterns(zp, zp);
    run_stream(85, 1'b0);
    drain();

    set_patterns(CW'($urandom), CW'($urandom));
    run_stream(110, 1'b1);
    drain();

    set_patterns(CW'($urandom), spd_pkg::REPEAT_PATTERN_RST);
    run_stream(110, 1'b0);
    drain();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[serial_pattern_demux_unit] OK");
    end else begin
      $display("[serial_pattern_demux_unit] ERROR");
    end
    $finish;
  end
endmodule

[filelist.f]
design/spd_pkg.sv
design/spd_core.sv
design/serial_pattern_demux_unit.sv
design/spd_checker.sv
verif/serial_pattern_demux_unit_tb.sv
